[rtl/assert_macros.svh]
// Assertion macros shared by the deframer RTL.
// Each macro clocks on the rising edge and is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/slsd_pkg.sv]
// Shared types, constants and helper functions for the sync/length/sum deframer.
// No dependencies; the parser, the result sequencer and the top level import this package.
`timescale 1ns / 1ps

package slsd_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;

    localparam int N_NAMES    = 7;
    localparam int NAME_BYTES = 16;

    localparam logic [7:0]  SYNC_C   = 8'h43;
    localparam logic [7:0]  SYNC_G   = 8'h47;
    localparam logic [15:0] SYNC_SUM = 16'h008A;

    localparam logic MODE_TIMEOUT = 1'b1;

    // Command names, right-justified: the first character sits in the highest used byte.
    localparam logic [8*NAME_BYTES-1:0] NAME_TEXT [N_NAMES] = '{
        "Change Usb A0B0",
        "Change Usb A0B1",
        "Change Usb A1B0",
        "Change Usb A1B1",
        "Get Voltage",
        "Get Device",
        "Get Fixture"
    };

    localparam logic [7:0] NAME_LEN [N_NAMES] = '{
        8'd15, 8'd15, 8'd15, 8'd15, 8'd11, 8'd10, 8'd11
    };

    localparam logic [N_NAMES-1:0] MASK_ALL = '1;

    typedef enum logic [2:0] {
        PH_HUNT_C,
        PH_HUNT_G,
        PH_CMD_LEN,
        PH_CMD_BYTES,
        PH_DATA_LEN,
        PH_DATA,
        PH_CHK_HI,
        PH_CHK_LO
    } phase_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_READ,
        EM_SHOW
    } emit_state_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [2:0] cmd_code;
        logic [7:0] data_byte;
        logic [5:0] data_count;
        logic [4:0] byte_index;
        logic       last;
    } res_item_t;

    // Handoff from the parser to the emitter when a frame passes all checks.
    typedef struct packed {
        logic       start;
        logic [2:0] code;
        logic [7:0] count;
    } frame_start_t;

    // True when byte b is the character at position pos of command name idx.
    function automatic logic name_byte_ok(input int unsigned idx, input logic [7:0] pos,
                                          input logic [7:0] b);
        logic [7:0] len;
        logic [7:0] sel;
        logic       ok;
        len = NAME_LEN[idx];
        sel = len - 8'd1 - pos;
        ok  = 1'b0;
        if (pos < len)
        begin
            ok = (NAME_TEXT[idx][{sel[3:0], 3'b000} +: 8] == b);
        end
        return ok;
    endfunction

    // Lowest set bit of the match mask gives the command code.
    function automatic logic [2:0] first_hit_code(input logic [N_NAMES-1:0] mask);
        logic [2:0] code;
        code = 3'd0;
        for (int i = N_NAMES - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                code = 3'(i);
            end
        end
        return code;
    endfunction

endpackage

[rtl/slsd_store.sv]
// Payload buffer: one write port, one read port with a registered read word.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module slsd_store #(
    parameter int MAX_PAYLOAD = 32,
    parameter int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [MAX_PAYLOAD];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/slsd_parser.sv]
// Frame parser: sync hunt, length fields, command name match, checksum verdict.
// Uses slsd_pkg; writes payload bytes into slsd_store.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module slsd_parser #(
    parameter int MAX_PAYLOAD = slsd_pkg::MAX_PAYLOAD_DEF,
    parameter int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  slsd_pkg::rx_item_t    item,
    output logic                  store_we,
    output logic [ADDR_W-1:0]     store_waddr,
    output logic [7:0]            store_wdata,
    output slsd_pkg::frame_start_t start
);

    import slsd_pkg::*;

    localparam logic [7:0] MAX_P8 = 8'(MAX_PAYLOAD);

    phase_t             phase_reg, phase_next;
    logic [7:0]         field_count_reg, field_count_next;
    logic [7:0]         name_length_reg, name_length_next;
    logic [7:0]         payload_length_reg, payload_length_next;
    logic [15:0]        running_sum_reg, running_sum_next;
    logic [7:0]         high_check_reg, high_check_next;
    logic [N_NAMES-1:0] mask_reg, mask_next;
    logic               burst_done_reg, burst_done_next;

    logic [7:0]  b;
    logic [7:0]  fc_inc;
    logic [15:0] sum_add;
    logic        active;
    logic        frame_ok;

    assign b       = item.rx_byte;
    assign fc_inc  = field_count_reg + 8'd1;
    assign sum_add = running_sum_reg + {8'd0, b};
    assign active  = accept && (item.mode != MODE_TIMEOUT) && !burst_done_reg;

    assign frame_ok = (high_check_reg == running_sum_reg[15:8]) &&
                      (b == running_sum_reg[7:0]) &&
                      (mask_reg != '0) &&
                      (payload_length_reg <= MAX_P8);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept && item.mode == MODE_TIMEOUT)
        begin
            phase_next = PH_HUNT_C;
        end
        else if (active)
        begin
            unique case (phase_reg)
                PH_HUNT_C:
                begin
                    if (b == SYNC_C)
                    begin
                        phase_next = PH_HUNT_G;
                    end
                end
                PH_HUNT_G:
                begin
                    if (b == SYNC_G)
                    begin
                        phase_next = PH_CMD_LEN;
                    end
                    else if (b != SYNC_C)
                    begin
                        phase_next = PH_HUNT_C;
                    end
                end
                PH_CMD_LEN:   phase_next = (b != 8'd0) ? PH_CMD_BYTES : PH_DATA_LEN;
                PH_CMD_BYTES:
                begin
                    if (fc_inc == name_length_reg)
                    begin
                        phase_next = PH_DATA_LEN;
                    end
                end
                PH_DATA_LEN:  phase_next = (b != 8'd0) ? PH_DATA : PH_CHK_HI;
                PH_DATA:
                begin
                    if (fc_inc == payload_length_reg)
                    begin
                        phase_next = PH_CHK_HI;
                    end
                end
                PH_CHK_HI:    phase_next = PH_CHK_LO;
                PH_CHK_LO:    phase_next = PH_HUNT_C;
            endcase
        end
    end

    // Field registers, store writes and the frame verdict.
    always_comb
    begin
        field_count_next    = field_count_reg;
        name_length_next    = name_length_reg;
        payload_length_next = payload_length_reg;
        running_sum_next    = running_sum_reg;
        high_check_next     = high_check_reg;
        mask_next           = mask_reg;
        burst_done_next     = burst_done_reg;
        store_we            = 1'b0;
        store_waddr         = field_count_reg[ADDR_W-1:0];
        store_wdata         = b;
        start.start         = 1'b0;
        start.code          = first_hit_code(mask_reg);
        start.count         = payload_length_reg;

        if (accept && item.mode == MODE_TIMEOUT)
        begin
            field_count_next    = 8'd0;
            name_length_next    = 8'd0;
            payload_length_next = 8'd0;
            running_sum_next    = 16'd0;
            high_check_next     = 8'd0;
            mask_next           = MASK_ALL;
            burst_done_next     = 1'b0;
        end
        else if (active)
        begin
            unique case (phase_reg)
                PH_HUNT_C:
                begin
                end
                PH_HUNT_G:
                begin
                    if (b == SYNC_G)
                    begin
                        running_sum_next = SYNC_SUM;
                    end
                end
                PH_CMD_LEN:
                begin
                    running_sum_next = sum_add;
                    name_length_next = b;
                    field_count_next = 8'd0;
                    for (int i = 0; i < N_NAMES; i++)
                    begin
                        mask_next[i] = (NAME_LEN[i] == b);
                    end
                end
                PH_CMD_BYTES:
                begin
                    running_sum_next = sum_add;
                    for (int i = 0; i < N_NAMES; i++)
                    begin
                        if (!name_byte_ok(i, field_count_reg, b))
                        begin
                            mask_next[i] = 1'b0;
                        end
                    end
                    field_count_next = fc_inc;
                end
                PH_DATA_LEN:
                begin
                    running_sum_next    = sum_add;
                    payload_length_next = b;
                    field_count_next    = 8'd0;
                end
                PH_DATA:
                begin
                    running_sum_next = sum_add;
                    // Bytes beyond the buffer still count toward the sum but are dropped.
                    store_we         = (field_count_reg < MAX_P8);
                    field_count_next = fc_inc;
                end
                PH_CHK_HI:
                begin
                    high_check_next = b;
                end
                PH_CHK_LO:
                begin
                    burst_done_next = 1'b1;
                    start.start     = frame_ok;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HUNT_C;
            field_count_reg    <= 8'd0;
            name_length_reg    <= 8'd0;
            payload_length_reg <= 8'd0;
            running_sum_reg    <= 16'd0;
            high_check_reg     <= 8'd0;
            mask_reg           <= MASK_ALL;
            burst_done_reg     <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            field_count_reg    <= field_count_next;
            name_length_reg    <= name_length_next;
            payload_length_reg <= payload_length_next;
            running_sum_reg    <= running_sum_next;
            high_check_reg     <= high_check_next;
            mask_reg           <= mask_next;
            burst_done_reg     <= burst_done_next;
        end
    end

    `ASSERT_CLK(a_store_in_range, clk, rst_n, store_we |-> (field_count_reg < MAX_P8), "payload write beyond buffer")
    `ASSERT_CLK(a_burst_sticky, clk, rst_n, (burst_done_reg && !(accept && item.mode == MODE_TIMEOUT)) |=> burst_done_reg, "burst ended without timeout")

endmodule

[rtl/slsd_emit.sv]
// Result sequencer: reads the payload buffer one word at a time and holds each
// result, shown from the buffer's read register, until taken. Uses slsd_pkg.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module slsd_emit #(
    parameter int MAX_PAYLOAD = slsd_pkg::MAX_PAYLOAD_DEF,
    parameter int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  slsd_pkg::frame_start_t start,
    output logic                   store_re,
    output logic [ADDR_W-1:0]      store_raddr,
    input  logic [7:0]             store_rdata,
    output logic                   res_valid,
    input  logic                   res_stall,
    output slsd_pkg::res_item_t    res_item,
    output logic                   busy
);

    import slsd_pkg::*;

    emit_state_t state_reg, state_next;
    logic [2:0]  code_reg;
    logic [7:0]  count_reg;
    logic [7:0]  index_reg;
    logic        empty_reg;
    logic        last_w;

    assign last_w = empty_reg || ((index_reg + 8'd1) == count_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (start.start)
                begin
                    state_next = (start.count == 8'd0) ? EM_SHOW : EM_READ;
                end
            end
            EM_READ: state_next = EM_SHOW;
            EM_SHOW:
            begin
                if (!res_stall)
                begin
                    state_next = last_w ? EM_IDLE : EM_READ;
                end
            end
            default: state_next = EM_IDLE;
        endcase
    end

    always_comb
    begin
        store_re            = (state_reg == EM_READ);
        store_raddr         = index_reg[ADDR_W-1:0];
        res_valid           = (state_reg == EM_SHOW);
        busy                = (state_reg != EM_IDLE);
        res_item.cmd_code   = code_reg;
        res_item.data_byte  = empty_reg ? 8'd0 : store_rdata;
        res_item.data_count = count_reg[5:0];
        res_item.byte_index = index_reg[4:0];
        res_item.last       = last_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == EM_IDLE && start.start)
        begin
            code_reg  <= start.code;
            count_reg <= start.count;
            index_reg <= 8'd0;
            empty_reg <= (start.count == 8'd0);
        end
        else if (state_reg == EM_SHOW && !res_stall && !last_w)
        begin
            index_reg <= index_reg + 8'd1;
        end
    end

    `ASSERT_NEVER(a_start_when_busy, clk, rst_n, start.start && busy, "frame verdict while results pending")
    `ASSERT_CLK(a_index_bound, clk, rst_n, (state_reg == EM_SHOW && !empty_reg) |-> (index_reg < count_reg), "result index past payload length")
    `ASSERT_CLK(a_last_ends, clk, rst_n, (res_valid && !res_stall && last_w) |=> (state_reg == EM_IDLE), "sequencer ran past final result")

endmodule

[rtl/sync_length_sum_deframer_core.sv]
// Top level of the sync/length/sum deframer: parser, payload buffer, result sequencer.
// Depends on slsd_pkg, slsd_parser, slsd_store and slsd_emit.
//
//  channel | direction | handshake             | word
//  rx      | in        | rx_valid / rx_stall   | rx_item  (mode, rx_byte)
//  res     | out       | res_valid / res_stall | res_item (cmd_code, data_byte, data_count,
//          |           |                       |           byte_index, last)
//
// An input word is taken whenever rx_valid is high and no results are pending.
// A good frame gives each result by a buffer read, after which the word is shown from
// the buffer's read register; an empty payload gives one zero result with no read. The
// result side may stall any shown word, and rx_stall is high until the last is taken.
// Reset is asynchronous and clears the parser and the sequencer state; the payload buffer
// holds whatever it held and is read only where the current frame wrote it.
`timescale 1ns / 1ps

module sync_length_sum_deframer_core #(
    parameter int MAX_PAYLOAD = slsd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_stall,
    input  slsd_pkg::rx_item_t  rx_item,
    output logic                res_valid,
    input  logic                res_stall,
    output slsd_pkg::res_item_t res_item
);

    import slsd_pkg::*;

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic              accept;
    logic              busy;
    logic              store_we;
    logic [ADDR_W-1:0] store_waddr;
    logic [7:0]        store_wdata;
    logic              store_re;
    logic [ADDR_W-1:0] store_raddr;
    logic [7:0]        store_rdata;
    frame_start_t      start;

    assign rx_stall = busy;
    assign accept   = rx_valid && !rx_stall;

    slsd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (rx_item),
        .store_we    (store_we),
        .store_waddr (store_waddr),
        .store_wdata (store_wdata),
        .start       (start)
    );

    slsd_store #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    slsd_emit #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .ADDR_W      (ADDR_W)
    ) u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .store_re    (store_re),
        .store_raddr (store_raddr),
        .store_rdata (store_rdata),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_item    (res_item),
        .busy        (busy)
    );

endmodule
